// File: sv/elu_pkg.sv
`timescale 1ns / 1ps

package elu_pkg;

   // Fraction bits of the exponent path and of the alpha register
   localparam int Q_BITS     = 30;
   localparam int EXP_W      = 31;
   localparam int SEG_BITS   = 26;
   localparam int ALPHA_BITS = 16;
   localparam int ALPHA_FRAC = 12;
   localparam int LOG2E_W    = 31;

   localparam logic [LOG2E_W-1:0]    LOG2E_Q30   = 31'd1549082005;
   localparam logic [EXP_W-1:0]      ONE_Q30     = 31'd1073741824;
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd4096;

   // Item between the exponent pipe and the scaling pipe
   typedef struct packed {
      logic             neg;
      logic [EXP_W-1:0] em1;
   } elu_mid_type;

   // 2^(-k/16) in Q30, k = 0..16
   function automatic logic [EXP_W-1:0] pow2_neg(input logic [4:0] k);
      logic [EXP_W-1:0] v;
      case (k)
         5'd0:    v = 31'd1073741824;
         5'd1:    v = 31'd1028218691;
         5'd2:    v = 31'd984625580;
         5'd3:    v = 31'd942880710;
         5'd4:    v = 31'd902905660;
         5'd5:    v = 31'd864625420;
         5'd6:    v = 31'd827968130;
         5'd7:    v = 31'd792865000;
         5'd8:    v = 31'd759250125;
         5'd9:    v = 31'd727060400;
         5'd10:   v = 31'd696235430;
         5'd11:   v = 31'd666717340;
         5'd12:   v = 31'd638450710;
         5'd13:   v = 31'd611382490;
         5'd14:   v = 31'd585461880;
         5'd15:   v = 31'd560640220;
         5'd16:   v = 31'd536870912;
         default: v = 31'd536870912;
      endcase
      return v;
   endfunction

endpackage

// File: sv/elu_req_if.sv
`timescale 1ns / 1ps

interface elu_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

// File: sv/elu_rsp_if.sv
`timescale 1ns / 1ps

interface elu_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// File: sv/elu_exp.sv
`timescale 1ns / 1ps

module elu_exp #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [SAMPLE_WIDTH-1:0]     in_sample,
   output logic                        out_valid,
   input  logic                        out_ready,
   output elu_pkg::elu_mid_type        out_mid,
   output logic [SAMPLE_WIDTH-1:0]     out_raw
);

   localparam int PW = SAMPLE_WIDTH + elu_pkg::LOG2E_W;
   localparam int EW = elu_pkg::EXP_W;
   localparam int SB = elu_pkg::SEG_BITS;
   localparam int QB = elu_pkg::Q_BITS;

   // Stage enables: a stage moves when empty or when the next one moves
   logic s1_go, s2_go, s3_go, s4_go;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;

   assign s4_go    = !s4_v_ff || out_ready;
   assign s3_go    = !s3_v_ff || s4_go;
   assign s2_go    = !s2_v_ff || s3_go;
   assign s1_go    = !s1_v_ff || s2_go;
   assign in_ready = s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s1_go) s1_v_ff <= in_valid;
         if (s2_go) s2_v_ff <= s1_v_ff;
         if (s3_go) s3_v_ff <= s2_v_ff;
         if (s4_go) s4_v_ff <= s3_v_ff;
      end
   end

   // Stage 1: magnitude of a negative sample
   logic [SAMPLE_WIDTH-1:0] mag_in, mag_ff, raw1_ff;
   logic                    neg1_ff;

   assign mag_in = SAMPLE_WIDTH'(~in_sample + 1'b1);

   always_ff @(posedge clock) begin
      if (s1_go) begin
         mag_ff  <= mag_in;
         raw1_ff <= in_sample;
         neg1_ff <= in_sample[SAMPLE_WIDTH-1];
      end
   end

   // Stage 2: exponent magnitude times log2 e
   logic [PW-1:0]           prod_in, prod_ff;
   logic [SAMPLE_WIDTH-1:0] raw2_ff;
   logic                    neg2_ff;

   assign prod_in = {{elu_pkg::LOG2E_W{1'b0}}, mag_ff}
                  * {{SAMPLE_WIDTH{1'b0}}, elu_pkg::LOG2E_Q30};

   always_ff @(posedge clock) begin
      if (s2_go) begin
         prod_ff <= prod_in;
         raw2_ff <= raw1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // Stage 3: split into shift and fraction, look up segment, start interpolation
   logic [63:0]             u;
   logic [3:0]              idx;
   logic [SB-1:0]           rem;
   logic [EW-1:0]           tab_a, tab_b;
   logic [SB-1:0]           diff;
   logic [2*SB-1:0]         dr_in, dr_ff;
   logic [EW-1:0]           a_ff;
   logic                    big_in, big_ff;
   logic [4:0]              sh_ff;
   logic [SAMPLE_WIDTH-1:0] raw3_ff;
   logic                    neg3_ff;

   assign u      = 64'(prod_ff) >> FRAC_BITS;
   assign idx    = u[QB-1:SB];
   assign rem    = u[SB-1:0];
   assign tab_a  = elu_pkg::pow2_neg({1'b0, idx});
   assign tab_b  = elu_pkg::pow2_neg(5'({1'b0, idx}) + 5'd1);
   assign diff   = SB'(tab_a - tab_b);
   assign dr_in  = {{SB{1'b0}}, diff} * {{SB{1'b0}}, rem};
   // Shifts of 31 or more clear a 31-bit value
   assign big_in = (u[63:QB] >= 34'd31);

   always_ff @(posedge clock) begin
      if (s3_go) begin
         a_ff    <= tab_a;
         dr_ff   <= dr_in;
         big_ff  <= big_in;
         sh_ff   <= u[QB+4:QB];
         raw3_ff <= raw2_ff;
         neg3_ff <= neg2_ff;
      end
   end

   // Stage 4: finish interpolation, shift, form 1 - exp(x)
   logic [EW-1:0]           m, e;
   elu_pkg::elu_mid_type    mid_in, mid_ff;
   logic [SAMPLE_WIDTH-1:0] raw4_ff;

   assign m          = a_ff - EW'(dr_ff[2*SB-1:SB]);
   assign e          = big_ff ? '0 : (m >> sh_ff);
   assign mid_in.neg = neg3_ff;
   assign mid_in.em1 = elu_pkg::ONE_Q30 - e;

   always_ff @(posedge clock) begin
      if (s4_go) begin
         mid_ff  <= mid_in;
         raw4_ff <= raw3_ff;
      end
   end

   assign out_valid = s4_v_ff;
   assign out_mid   = mid_ff;
   assign out_raw   = raw4_ff;

endmodule

// File: sv/elu_scale.sv
`timescale 1ns / 1ps

module elu_scale #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [elu_pkg::ALPHA_BITS-1:0]     alpha,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  elu_pkg::elu_mid_type               in_mid,
   input  logic [SAMPLE_WIDTH-1:0]            in_raw,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [SAMPLE_WIDTH-1:0]            out_sample
);

   localparam int EW  = elu_pkg::EXP_W;
   localparam int AW  = elu_pkg::ALPHA_BITS;
   localparam int MW  = EW + AW;
   localparam int RSH = elu_pkg::Q_BITS + elu_pkg::ALPHA_FRAC - FRAC_BITS;

   logic s5_go, s6_go;
   logic s5_v_ff, s6_v_ff;

   assign s6_go    = !s6_v_ff || out_ready;
   assign s5_go    = !s5_v_ff || s6_go;
   assign in_ready = s5_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else begin
         if (s5_go) s5_v_ff <= in_valid;
         if (s6_go) s6_v_ff <= s5_v_ff;
      end
   end

   // Stage 5: scale by alpha
   logic [MW-1:0]           prod_in, prod_ff;
   logic [SAMPLE_WIDTH-1:0] raw5_ff;
   logic                    neg5_ff;

   assign prod_in = {{AW{1'b0}}, in_mid.em1} * {{EW{1'b0}}, alpha};

   always_ff @(posedge clock) begin
      if (s5_go) begin
         prod_ff <= prod_in;
         raw5_ff <= in_raw;
         neg5_ff <= in_mid.neg;
      end
   end

   // Stage 6: round half away, saturate, negate; pass non-negative samples
   logic [MW:0]             rounded, half, sat;
   logic [SAMPLE_WIDTH-1:0] out_in, out_ff;

   assign rounded = ({1'b0, prod_ff} + ((MW+1)'(1) << (RSH - 1))) >> RSH;
   assign half    = (MW+1)'(1) << (SAMPLE_WIDTH - 1);
   assign sat     = (rounded > half) ? half : rounded;
   assign out_in  = neg5_ff ? SAMPLE_WIDTH'((MW+1)'(0) - sat) : raw5_ff;

   always_ff @(posedge clock) begin
      if (s6_go) out_ff <= out_in;
   end

   assign out_valid  = s6_v_ff;
   assign out_sample = out_ff;

   // 1 - exp(x) never exceeds one
   a_em1_range: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (in_mid.em1 <= elu_pkg::ONE_Q30))
      else $error("em1 above one");

   // A full stage 5 that moves lands in the output register
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s5_v_ff && s6_go) |=> s6_v_ff)
      else $error("word lost between stage 5 and output");

   // Negative samples never give a positive result
   a_neg_sign: assert property (@(posedge clock) disable iff (reset)
      (s5_v_ff && neg5_ff && s6_go) |=>
         (out_ff[SAMPLE_WIDTH-1] || (out_ff == '0)))
      else $error("negative sample gave positive result");

endmodule

// File: sv/elu_activation.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Word
// req_port  in   valid/ready   sample_in  : signed Q(SAMPLE_WIDTH-FRAC_BITS).FRAC_BITS
// rsp_port  out  valid/ready   sample_out : signed, same format, rounded and saturated
// csr       in   csr_wr_en     csr_wr_data: alpha, unsigned Q4.12
//
// One word per cycle sustained while rsp_port is ready. Accepted words pass in order
// through registered stages: magnitude, log2 e product, table interpolation
// multiply, shift and 1 - exp(x), alpha product, then round and saturate.
// Reset clears all stage valid bits and sets alpha to 1.0; no clearing pass.
// A stall on rsp_port fills empty stages first, then backs up to req_port.

module elu_activation #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   elu_req_if.sink                        req_port,
   elu_rsp_if.source                      rsp_port,
   input  logic                           csr_wr_en,
   input  logic [elu_pkg::ALPHA_BITS-1:0] csr_wr_data
);

   // Alpha register
   logic [elu_pkg::ALPHA_BITS-1:0] alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= elu_pkg::ALPHA_RESET;
      end else if (csr_wr_en) begin
         alpha_ff <= csr_wr_data;
      end
   end

   elu_pkg::elu_mid_type    mid;
   logic [SAMPLE_WIDTH-1:0] mid_raw;
   logic                    mid_valid, mid_ready;
   logic [SAMPLE_WIDTH-1:0] res_sample;

   // Exponent pipe: magnitude, log2 e product, table, shift
   elu_exp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_ready  (req_port.ready),
      .in_sample (SAMPLE_WIDTH'(req_port.sample_in)),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_mid   (mid),
      .out_raw   (mid_raw)
   );

   // Scaling pipe: alpha product, round, saturate
   elu_scale #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .alpha      (alpha_ff),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_mid     (mid),
      .in_raw     (mid_raw),
      .out_valid  (rsp_port.valid),
      .out_ready  (rsp_port.ready),
      .out_sample (res_sample)
   );

   assign rsp_port.sample_out = $signed(res_sample);

endmodule
